/* design/gfsx_pkg.sv */
// Shared types, codes and pattern tables for the gap framed sum/XOR frame checker.
`default_nettype none

package gfsx_pkg;

    // Verdict codes
    typedef enum logic [1:0] {
        ST_GOOD   = 2'd0,
        ST_BAD    = 2'd1,
        ST_SHORT  = 2'd2,
        ST_STATUS = 2'd3
    } frame_status_t;

    // Configuration register indexes
    localparam logic CFG_GAP_TICKS = 1'b0;
    localparam logic CFG_MAX_LEN   = 1'b1;

    // Reset values of the configuration registers
    localparam logic [15:0] GAP_TICKS_RST = 16'd5;
    localparam logic [7:0]  MAX_LEN_RST   = 8'd100;

    // Bit positions in the pattern match flags
    localparam int FLAG_TTM  = 0;
    localparam int FLAG_OK   = 1;
    localparam int FLAG_DISC = 2;

    // Offsets and lengths of the status line patterns
    localparam logic [7:0] PAT_BODY_OFS = 8'd4;
    localparam logic [7:0] TTM_MIN_LEN  = 8'd3;
    localparam logic [7:0] OK_END       = 8'd8;
    localparam logic [7:0] DISC_END     = 8'd13;
    localparam logic [7:0] CSUM_MIN_LEN = 8'd2;

    // Verdict handed from the frame core to the output register
    typedef struct packed {
        logic          valid;
        frame_status_t status;
        logic [7:0]    length;
        logic [7:0]    cmd;
        logic          connected;
    } verdict_t;

    // Status line prefix "TTM"
    function automatic logic [7:0] prefix_char(input logic [1:0] idx);
        logic [7:0] c;
        case (idx)
            2'd0:    c = "T";
            2'd1:    c = "T";
            2'd2:    c = "M";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // Connect pattern "OK\r\n"
    function automatic logic [7:0] ok_char(input logic [1:0] idx);
        logic [7:0] c;
        case (idx)
            2'd0:    c = "O";
            2'd1:    c = "K";
            2'd2:    c = 8'h0D;
            default: c = 8'h0A;
        endcase
        return c;
    endfunction

    // Disconnect pattern "DISCONNET"
    function automatic logic [7:0] disc_char(input logic [3:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0:    c = "D";
            4'd1:    c = "I";
            4'd2:    c = "S";
            4'd3:    c = "C";
            4'd4:    c = "O";
            4'd5:    c = "N";
            4'd6:    c = "N";
            4'd7:    c = "E";
            4'd8:    c = "T";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

/* design/gfsx_frame_core.sv */
// Frame state, gap/length framing, pattern matching and checksum verdict.
`default_nettype none

module gfsx_frame_core #(
    parameter int MAX_FRAME = 128
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              item_en,
    input  wire logic              req_type,
    input  wire logic [7:0]        rx_byte,
    input  wire logic [15:0]       gap_ticks,
    input  wire logic [7:0]        max_frame_len,
    output gfsx_pkg::verdict_t     verdict
);
    import gfsx_pkg::*;

    localparam logic [7:0] MAX_LIM = 8'(MAX_FRAME);

    logic [7:0]  byte_count_reg,  byte_count_next;
    logic [15:0] idle_ticks_reg,  idle_ticks_next;
    logic [7:0]  lagged_sum_reg,  lagged_sum_next;
    logic [7:0]  lagged_xor_reg,  lagged_xor_next;
    logic [15:0] last_two_reg,    last_two_next;
    logic [7:0]  first_byte_reg,  first_byte_next;
    logic [2:0]  flags_reg,       flags_next;
    logic        connected_reg,   connected_next;

    logic [7:0]  cnt_upd, sum_upd, xor_upd, first_upd, limit;
    logic [15:0] idle_upd, last_upd, gap_eff;
    logic [2:0]  flags_upd;
    logic [7:0]  ofs;
    logic        end_frame, conn_upd;
    frame_status_t status;

    always_comb begin
        // Defaults: hold the running values
        cnt_upd   = byte_count_reg;
        idle_upd  = idle_ticks_reg;
        sum_upd   = lagged_sum_reg;
        xor_upd   = lagged_xor_reg;
        last_upd  = last_two_reg;
        first_upd = first_byte_reg;
        flags_upd = flags_reg;
        end_frame = 1'b0;
        ofs       = byte_count_reg - PAT_BODY_OFS;

        gap_eff = (gap_ticks == 16'd0) ? 16'd1 : gap_ticks;
        limit   = (max_frame_len == 8'd0) ? 8'd1 : max_frame_len;
        if (limit > MAX_LIM) begin
            limit = MAX_LIM;
        end

        if (item_en) begin
            if (req_type) begin
                // Count idle ticks of an open frame
                if (byte_count_reg != 8'd0) begin
                    if (idle_ticks_reg != 16'hFFFF) begin
                        idle_upd = idle_ticks_reg + 16'd1;
                    end
                    end_frame = (idle_upd >= gap_eff);
                end
            end else begin
                // Take in a byte: patterns, lagged checksum, history
                if (byte_count_reg == 8'd0) begin
                    first_upd = rx_byte;
                end
                if (byte_count_reg < TTM_MIN_LEN &&
                    rx_byte != prefix_char(byte_count_reg[1:0])) begin
                    flags_upd[FLAG_TTM] = 1'b0;
                end
                if (byte_count_reg >= PAT_BODY_OFS && byte_count_reg < OK_END &&
                    rx_byte != ok_char(ofs[1:0])) begin
                    flags_upd[FLAG_OK] = 1'b0;
                end
                if (byte_count_reg >= PAT_BODY_OFS && byte_count_reg < DISC_END &&
                    rx_byte != disc_char(ofs[3:0])) begin
                    flags_upd[FLAG_DISC] = 1'b0;
                end
                if (byte_count_reg >= CSUM_MIN_LEN) begin
                    sum_upd = lagged_sum_reg + last_two_reg[15:8];
                    xor_upd = lagged_xor_reg ^ last_two_reg[15:8];
                end
                last_upd  = {last_two_reg[7:0], rx_byte};
                cnt_upd   = byte_count_reg + 8'd1;
                idle_upd  = 16'd0;
                end_frame = (cnt_upd >= limit);
            end
        end

        // Form the verdict of an ended frame
        conn_upd = connected_reg;
        if (flags_upd[FLAG_TTM] && cnt_upd >= TTM_MIN_LEN) begin
            status = ST_STATUS;
            if (flags_upd[FLAG_OK] && cnt_upd >= OK_END) begin
                conn_upd = 1'b1;
            end else if (flags_upd[FLAG_DISC] && cnt_upd >= DISC_END) begin
                conn_upd = 1'b0;
            end
        end else if (cnt_upd < CSUM_MIN_LEN) begin
            status = ST_SHORT;
        end else if (sum_upd == last_upd[15:8] && xor_upd == last_upd[7:0]) begin
            status = ST_GOOD;
        end else begin
            status = ST_BAD;
        end

        verdict.valid     = end_frame;
        verdict.status    = status;
        verdict.length    = cnt_upd;
        verdict.cmd       = first_upd;
        verdict.connected = conn_upd;

        // Clear frame state after a verdict
        if (end_frame) begin
            byte_count_next = 8'd0;
            idle_ticks_next = 16'd0;
            lagged_sum_next = 8'd0;
            lagged_xor_next = 8'd0;
            last_two_next   = 16'd0;
            first_byte_next = 8'd0;
            flags_next      = 3'b111;
            connected_next  = conn_upd;
        end else begin
            byte_count_next = cnt_upd;
            idle_ticks_next = idle_upd;
            lagged_sum_next = sum_upd;
            lagged_xor_next = xor_upd;
            last_two_next   = last_upd;
            first_byte_next = first_upd;
            flags_next      = flags_upd;
            connected_next  = connected_reg;
        end
    end

    // Hold frame state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_count_reg <= 8'd0;
            idle_ticks_reg <= 16'd0;
            lagged_sum_reg <= 8'd0;
            lagged_xor_reg <= 8'd0;
            last_two_reg   <= 16'd0;
            first_byte_reg <= 8'd0;
            flags_reg      <= 3'b111;
            connected_reg  <= 1'b0;
        end else begin
            byte_count_reg <= byte_count_next;
            idle_ticks_reg <= idle_ticks_next;
            lagged_sum_reg <= lagged_sum_next;
            lagged_xor_reg <= lagged_xor_next;
            last_two_reg   <= last_two_next;
            first_byte_reg <= first_byte_next;
            flags_reg      <= flags_next;
            connected_reg  <= connected_next;
        end
    end

endmodule

`default_nettype wire

/* design/gap_framed_sum_xor_frame_checker.sv */
// A verdict appears on the m_ side in the cycle after the transaction that ends its frame.
// Throughput: one input transaction per cycle; each is handled in a single pass through
// the frame core, and the output register takes a new verdict in the cycle the old one leaves.
// Input stalls only while a verdict is held and m_ready is low.
// Reset (aresetn, synchronous, active low) clears frame state, the connected flag and the
// output valid, and returns gap_ticks to 5 and max_frame_len to 100.
`default_nettype none

module gap_framed_sum_xor_frame_checker #(
    parameter int MAX_FRAME = 128
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_index,
    input  wire logic [15:0] cfg_wdata,
    input  wire logic        s_valid,
    output      logic        s_ready,
    input  wire logic        s_req_type,
    input  wire logic [7:0]  s_rx_byte,
    output      logic        m_valid,
    input  wire logic        m_ready,
    output      logic [1:0]  m_frame_status,
    output      logic [7:0]  m_frame_length,
    output      logic [7:0]  m_command_byte,
    output      logic        m_link_connected
);
    import gfsx_pkg::*;

    logic [15:0] gap_ticks_reg;
    logic [7:0]  max_len_reg;
    logic        m_valid_reg;
    logic [1:0]  status_reg;
    logic [7:0]  length_reg;
    logic [7:0]  cmd_reg;
    logic        conn_reg;
    logic        accept;
    verdict_t    verdict;

    // Accept whenever the output register is free or being emptied
    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    gfsx_frame_core #(
        .MAX_FRAME(MAX_FRAME)
    ) u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .item_en      (accept),
        .req_type     (s_req_type),
        .rx_byte      (s_rx_byte),
        .gap_ticks    (gap_ticks_reg),
        .max_frame_len(max_len_reg),
        .verdict      (verdict)
    );

    // Write configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gap_ticks_reg <= GAP_TICKS_RST;
            max_len_reg   <= MAX_LEN_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_GAP_TICKS: gap_ticks_reg <= cfg_wdata;
                CFG_MAX_LEN:   max_len_reg   <= cfg_wdata[7:0];
                default:       ;
            endcase
        end
    end

    // Load a verdict into the output register, drop it once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (verdict.valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (verdict.valid) begin
            status_reg <= verdict.status;
            length_reg <= verdict.length;
            cmd_reg    <= verdict.cmd;
            conn_reg   <= verdict.connected;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_frame_status   = status_reg;
    assign m_frame_length   = length_reg;
    assign m_command_byte   = cmd_reg;
    assign m_link_connected = conn_reg;

endmodule

`default_nettype wire

/* design/gfsx_checker.sv */
// Port-level assertions for the frame checker and the bind that attaches them.
`default_nettype none

module gfsx_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_ready,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic [1:0] m_frame_status,
    input wire logic [7:0] m_frame_length,
    input wire logic [7:0] m_command_byte,
    input wire logic       m_link_connected
);
    import gfsx_pkg::*;

    // Stalled verdict holds its payload
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_frame_status) &&
        $stable(m_frame_length) && $stable(m_command_byte) && $stable(m_link_connected))
        else $error("verdict changed while stalled");

    // Input stalls while a verdict waits
    a_back_press: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("input accepted while output register full");

    // Every verdict covers at least one byte
    a_len_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_frame_length != 8'd0)
        else $error("verdict with zero length");

    // Too short means a single byte
    a_short_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_frame_status == ST_SHORT |-> m_frame_length == 8'd1)
        else $error("too short verdict with wrong length");

    // Checksum verdicts need the two checksum bytes
    a_csum_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_frame_status == ST_GOOD || m_frame_status == ST_BAD)
        |-> m_frame_length >= 8'd2)
        else $error("checksum verdict on frame under two bytes");

endmodule

bind gap_framed_sum_xor_frame_checker gfsx_checker u_gfsx_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_ready         (s_ready),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_frame_status  (m_frame_status),
    .m_frame_length  (m_frame_length),
    .m_command_byte  (m_command_byte),
    .m_link_connected(m_link_connected)
);

`default_nettype wire
